// File: rtl/core/sha1_hash_core_assert.svh
// Assertion macros shared by the SHA-1 core modules.
`ifndef SHA1_HASH_CORE_ASSERT_SVH
`define SHA1_HASH_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define SHA1_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define SHA1_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/sha1_pkg.sv
// Types, constants and round functions for the SHA-1 core.
`default_nettype none
package sha1_pkg;

  typedef logic [31:0]      sha1_word_t;
  typedef logic [4:0][31:0] sha1_vars_t;

  // Control into the compression unit
  typedef struct packed {
    logic       start;
    logic       push;
    sha1_word_t word;
  } sha1_ctrl_t;

  // Status back from the compression unit
  typedef struct packed {
    logic busy;
    logic done;
  } sha1_stat_t;

  localparam sha1_vars_t SHA1_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [6:0] ROUND_LAST   = 7'd79;
  localparam logic [3:0] POS_LAST     = 4'd15;
  localparam logic [3:0] POS_LEN_HI   = 4'd14;
  localparam logic [2:0] BYTES_FULL   = 3'd4;
  localparam logic [2:0] DIGEST_LAST  = 3'd4;
  localparam sha1_word_t PAD_MARK     = 32'h8000_0000;

  // Round group codes
  localparam logic [1:0] PH_CH     = 2'd0;
  localparam logic [1:0] PH_PAR1   = 2'd1;
  localparam logic [1:0] PH_MAJ    = 2'd2;
  localparam logic [1:0] PH_PAR2   = 2'd3;

  function automatic logic [1:0] sha1_phase(input logic [6:0] round);
    if (round < 7'd20)      return PH_CH;
    else if (round < 7'd40) return PH_PAR1;
    else if (round < 7'd60) return PH_MAJ;
    else                    return PH_PAR2;
  endfunction

  function automatic sha1_word_t sha1_f(input logic [1:0] ph, input sha1_word_t b,
                                        input sha1_word_t c, input sha1_word_t d);
    sha1_word_t r;
    case (ph)
      PH_CH:   r = (b & c) | (~b & d);
      PH_MAJ:  r = (b & c) | (c & d) | (d & b);
      default: r = b ^ c ^ d;
    endcase
    return r;
  endfunction

  function automatic sha1_word_t sha1_k(input logic [1:0] ph);
    sha1_word_t r;
    case (ph)
      PH_CH:   r = 32'h5A827999;
      PH_PAR1: r = 32'h6ED9EBA1;
      PH_MAJ:  r = 32'h8F1BBCDC;
      default: r = 32'hCA62C1D6;
    endcase
    return r;
  endfunction

  // Keep the valid top bytes of the last word and append the marker byte if a byte is free
  function automatic sha1_word_t sha1_pad_word(input sha1_word_t w, input logic [2:0] n);
    sha1_word_t r;
    case (n)
      3'd0:    r = PAD_MARK;
      3'd1:    r = {w[31:24], 8'h80, 16'h0000};
      3'd2:    r = {w[31:16], 8'h80, 8'h00};
      3'd3:    r = {w[31:8], 8'h80};
      default: r = w;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/sha1_hash_core.sv
// SHA-1 hash core top level: word loading, padding, sequencing and digest output.
//
// Input channel (in_valid/in_ready): one big-endian 32-bit message word per item.
// in_last_word marks the final word; in_byte_count (valid top bytes, values
// above four count as four) is read on that word only.
// Output channel (out_valid/out_ready): five digest words H0..H4 follow each
// message, out_digest_last set on H4.
// After every sixteenth word the compression runs (a load step, 80 rounds in
// the single round unit and an add into the hash state) and in_ready stays low
// meanwhile, so no new word is taken until the compression is through.
// After the last word the padding words are pushed one per cycle and one or
// two more compressions run; the digest then appears, one word per cycle
// that out_ready is high. A stalled receiver holds the current digest word
// and keeps in_ready low. After H4 is taken the hash state, length and word
// position return to their initial values and in_ready rises.
// Synchronous reset (rst_n low) restores the same initial state.
`default_nettype none
`include "sha1_hash_core_assert.svh"
module sha1_hash_core
  import sha1_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_message_word,
  input  wire logic [2:0]  in_byte_count,
  input  wire logic        in_last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic             out_digest_last
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [3:0]  pos_r;
  logic [63:0] len_r;
  logic        pad_r, p80_r, hi_r, lo_r;
  logic [2:0]  idx_r;
  sha1_vars_t  hash_r;

  logic [2:0]  nsat;
  logic        push_en;
  sha1_word_t  push_word;
  sha1_ctrl_t  ctrl;
  sha1_stat_t  stat;
  sha1_vars_t  vars;

  sha1_compress u_comp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .hash_in (hash_r),
    .stat    (stat),
    .vars    (vars)
  );

  assign nsat = (in_byte_count > BYTES_FULL) ? BYTES_FULL : in_byte_count;

  // Pick the pushed word and the next state
  always_comb begin
    push_en   = 1'b0;
    push_word = '0;
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          push_en   = 1'b1;
          push_word = in_last_word ? sha1_pad_word(in_message_word, nsat) : in_message_word;
          if (pos_r == POS_LAST)  state_nxt = S_START;
          else if (in_last_word)  state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        push_en = 1'b1;
        if (p80_r)                            push_word = PAD_MARK;
        else if (!hi_r && pos_r == POS_LEN_HI) push_word = len_r[63:32];
        else if (hi_r)                        push_word = len_r[31:0];
        else                                  push_word = '0;
        if (pos_r == POS_LAST) state_nxt = S_START;
      end
      S_START: state_nxt = S_RUN;
      S_RUN: begin
        if (stat.done) begin
          if (lo_r)       state_nxt = S_OUT;
          else if (pad_r) state_nxt = S_PAD;
          else            state_nxt = S_LOAD;
        end
      end
      S_OUT: begin
        if (out_ready && idx_r == DIGEST_LAST) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  assign ctrl.start = (state_r == S_START);
  assign ctrl.push  = push_en;
  assign ctrl.word  = push_word;

  // Sequencer, length and hash state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      pos_r   <= '0;
      len_r   <= '0;
      pad_r   <= 1'b0;
      p80_r   <= 1'b0;
      hi_r    <= 1'b0;
      lo_r    <= 1'b0;
      idx_r   <= '0;
      hash_r  <= SHA1_INIT;
    end else begin
      state_r <= state_nxt;
      if (push_en) pos_r <= pos_r + 4'd1;
      case (state_r)
        S_LOAD: begin
          if (in_valid) begin
            if (in_last_word) begin
              len_r <= len_r + {58'd0, nsat, 3'd0};
              pad_r <= 1'b1;
              p80_r <= (nsat == BYTES_FULL);
            end else begin
              len_r <= len_r + 64'd32;
            end
          end
        end
        S_PAD: begin
          if (p80_r)                             p80_r <= 1'b0;
          else if (!hi_r && pos_r == POS_LEN_HI) hi_r  <= 1'b1;
          else if (hi_r)                         lo_r  <= 1'b1;
        end
        S_RUN: begin
          if (stat.done) begin
            for (int i = 0; i < 5; i++) hash_r[i] <= hash_r[i] + vars[i];
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (idx_r == DIGEST_LAST) begin
              idx_r  <= '0;
              hash_r <= SHA1_INIT;
              len_r  <= '0;
              pos_r  <= '0;
              pad_r  <= 1'b0;
              p80_r  <= 1'b0;
              hi_r   <= 1'b0;
              lo_r   <= 1'b0;
            end else begin
              idx_r <= idx_r + 3'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ready        = (state_r == S_LOAD);
  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = hash_r[idx_r];
  assign out_digest_last = (idx_r == DIGEST_LAST);

  `SHA1_ASSERT_NOW(a_one_side, 1'b1, !(in_ready && out_valid), "both channels open")
  `SHA1_ASSERT_NOW(a_done_run, stat.done, state_r == S_RUN, "round done outside run")
  `SHA1_ASSERT_NOW(a_start_full, state_r == S_START, pos_r == 4'd0, "start on partial block")
  `SHA1_ASSERT_NOW(a_load_quiet, state_r == S_LOAD, !stat.busy, "rounds while loading")
  `SHA1_ASSERT_NEXT(a_restart, out_valid && out_ready && out_digest_last,
                    in_ready && pos_r == 4'd0 && len_r == 64'd0, "no restart after digest")

endmodule
`default_nettype wire

// File: rtl/core/sha1_compress.sv
// SHA-1 compression unit: schedule shift line, working variables, one round per cycle.
`default_nettype none
`include "sha1_hash_core_assert.svh"
module sha1_compress
  import sha1_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire sha1_ctrl_t ctrl,
  input  wire sha1_vars_t hash_in,
  output sha1_stat_t      stat,
  output sha1_vars_t      vars
);

  sha1_word_t       win_r [16];
  sha1_vars_t       vars_r;
  logic [6:0]       round_r;
  logic             busy_r;
  logic             done_r;

  logic [1:0]       ph;
  sha1_word_t       a, b, c, d, e;
  sha1_word_t       tmp;
  sha1_word_t       sched_x;
  sha1_word_t       sched;

  // One round of the shared datapath
  always_comb begin
    a       = vars_r[0];
    b       = vars_r[1];
    c       = vars_r[2];
    d       = vars_r[3];
    e       = vars_r[4];
    ph      = sha1_phase(round_r);
    tmp     = {a[26:0], a[31:27]} + sha1_f(ph, b, c, d) + e + sha1_k(ph) + win_r[0];
    sched_x = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
    sched   = {sched_x[30:0], sched_x[31]};
  end

  // Shift the window on a load push or on every round
  always_ff @(posedge clk) begin
    if (ctrl.push || busy_r) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i + 1];
      win_r[15] <= ctrl.push ? ctrl.word : sched;
    end
  end

  // Load and advance the working variables
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      vars_r <= hash_in;
    end else if (busy_r) begin
      vars_r <= {d, c, {b[1:0], b[31:2]}, a, tmp};
    end
  end

  // Count rounds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      round_r <= '0;
    end else begin
      done_r <= busy_r && (round_r == ROUND_LAST);
      if (ctrl.start) begin
        busy_r  <= 1'b1;
        round_r <= '0;
      end else if (busy_r) begin
        round_r <= round_r + 7'd1;
        if (round_r == ROUND_LAST) busy_r <= 1'b0;
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign vars      = vars_r;

  `SHA1_ASSERT_NOW(a_start_idle, ctrl.start, !busy_r && !ctrl.push, "start while busy")
  `SHA1_ASSERT_NOW(a_push_idle, ctrl.push, !busy_r, "window push during rounds")
  `SHA1_ASSERT_NOW(a_done_idle, done_r, !busy_r, "done while rounds run")

endmodule
`default_nettype wire
